@@ src/u8d_pkg.sv @@
// u8d_pkg: shared constants, types and helpers for the utf-8 code point decoder
// no dependencies; used by the controller, the datapath and the top level
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned BUF_D  = 4;

  localparam logic [CP_W-1:0] ERR_CP = 21'h00003F;

  localparam logic [CNT_W-1:0] NEED_BAD = 3'd0;
  localparam logic [CNT_W-1:0] NEED_ONE = 3'd1;
  localparam logic [CNT_W-1:0] NEED_TWO = 3'd2;
  localparam logic [CNT_W-1:0] NEED_THR = 3'd3;
  localparam logic [CNT_W-1:0] NEED_FOU = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic push;
    logic push_last;
  } u8d_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic brk;
    logic last;
    logic hold_valid;
    logic out_free;
  } u8d_sts_t;

  // sequence length from the lead byte, zero for a stray byte
  function automatic logic [CNT_W-1:0] seq_len(input logic [BYTE_W-1:0] c0);
    logic [CNT_W-1:0] n;
    n = NEED_BAD;
    if (c0[7] == 1'b0)             n = NEED_ONE;
    else if (c0[7:5] == 3'b110)    n = NEED_TWO;
    else if (c0[7:4] == 4'b1110)   n = NEED_THR;
    else if (c0[7:3] == 5'b11110)  n = NEED_FOU;
    return n;
  endfunction

endpackage

@@ src/u8d_if.sv @@
// u8d_in_if / u8d_out_if: valid-ready channels for input bytes and decoded results
// depends on u8d_pkg for field widths
interface u8d_in_if import u8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              text_last;

  modport source (output valid, output byte_value, output text_last, input ready);
  modport sink   (input valid, input byte_value, input text_last, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            run_last;

  modport source (output valid, output code_point, output run_last, input ready);
  modport sink   (input valid, input code_point, input run_last, output ready);
endinterface

@@ src/u8d_datapath.sv @@
// u8d_datapath: byte window, one decode step per cycle while advance is given, held result and output register
// depends on u8d_pkg; driven by u8d_ctrl through u8d_cmd_t / u8d_sts_t
module u8d_datapath import u8d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  u8d_cmd_t          cmd,
  output u8d_sts_t          sts,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              in_text_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic              out_run_last
);

  logic [BYTE_W-1:0] buf_r [BUF_D];
  logic [BYTE_W-1:0] buf_nxt [BUF_D];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_r;
  logic              hold_valid_r, hold_valid_nxt;
  logic [CP_W-1:0]   hold_cp_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   code_point_r;
  logic              run_last_r;

  logic [CNT_W-1:0]  need;
  logic              empty, brk, cont_ok, emit;
  logic [CNT_W-1:0]  consume;
  logic [CP_W-1:0]   cp;
  logic [CNT_W-1:0]  src_idx [BUF_D];

  always_comb begin
    need  = seq_len(buf_r[0]);
    empty = (cnt_r == '0);
    brk   = !empty && (need > NEED_ONE) && (cnt_r < need);
    // trailing bytes of the sequence inside the window must all be continuation bytes
    cont_ok = 1'b1;
    for (int i = 1; i < BUF_D; i++) begin
      if ((CNT_W'(i) < need) && (buf_r[i][7:6] != 2'b10)) cont_ok = 1'b0;
    end
    emit = !empty && (!brk || last_r);

    consume = NEED_ONE;
    cp      = ERR_CP;
    if (brk) begin
      consume = cnt_r;
    end else begin
      case (need)
        NEED_ONE: cp = {{(CP_W-BYTE_W){1'b0}}, buf_r[0]};
        NEED_TWO: begin
          if (cont_ok) begin
            cp      = {10'b0, buf_r[0][4:0], buf_r[1][5:0]};
            consume = NEED_TWO;
          end
        end
        NEED_THR: begin
          if (cont_ok) begin
            cp      = {5'b0, buf_r[0][3:0], buf_r[1][5:0], buf_r[2][5:0]};
            consume = NEED_THR;
          end
        end
        NEED_FOU: begin
          if (cont_ok) begin
            cp = {buf_r[0][2:0], buf_r[1][5:0], buf_r[2][5:0], buf_r[3][5:0]};
            consume = NEED_FOU;
          end
        end
        default: cp = ERR_CP;
      endcase
    end

    // shift the window left by the consumed bytes
    for (int i = 0; i < BUF_D; i++) begin
      src_idx[i] = CNT_W'(i) + consume;
      buf_nxt[i] = (src_idx[i] < CNT_W'(BUF_D)) ? buf_r[src_idx[i][1:0]] : buf_r[i];
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.push) begin
      out_valid_nxt  = 1'b1;
      hold_valid_nxt = 1'b0;
    end
    if (cmd.load) cnt_nxt = cnt_r + CNT_W'(1);
    if (cmd.advance) begin
      cnt_nxt = cnt_r - consume;
      if (emit) hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_r[cnt_r[1:0]] <= in_byte_value;
      last_r            <= in_text_last;
    end
    if (cmd.advance) begin
      for (int i = 0; i < BUF_D; i++) buf_r[i] <= buf_nxt[i];
      if (emit) hold_cp_r <= cp;
    end
    if (cmd.push) begin
      code_point_r <= hold_cp_r;
      run_last_r   <= cmd.push_last;
    end
  end

  assign sts.empty      = empty;
  assign sts.brk        = brk;
  assign sts.last       = last_r;
  assign sts.hold_valid = hold_valid_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_code_point = code_point_r;
  assign out_run_last   = run_last_r;

endmodule

@@ src/u8d_ctrl.sv @@
// u8d_ctrl: two-state controller sequencing load, decode steps and result transfers
// depends on u8d_pkg; commands u8d_datapath
module u8d_ctrl import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  u8d_sts_t sts,
  output u8d_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic fin;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = (state_r == S_IDLE);
    // nothing more to decode: window empty or waiting for more bytes
    fin = sts.empty || (sts.brk && !sts.last);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (fin) begin
          if (!sts.hold_valid) begin
            state_nxt = S_IDLE;
          end else if (sts.out_free) begin
            cmd.push      = 1'b1;
            cmd.push_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (!sts.hold_valid) begin
          cmd.advance = 1'b1;
        end else if (sts.out_free) begin
          // held result is known not to be the last one for this byte
          cmd.push    = 1'b1;
          cmd.advance = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free) else $error("result transfer into a busy output register");

  a_hold_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && sts.hold_valid) |-> cmd.push) else $error("held result overwritten");

  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN)) else $error("load did not start decoding");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.hold_valid) else $error("result left behind in idle");
`endif

endmodule

@@ src/utf8_code_point_decoder_core.sv @@
// utf8_code_point_decoder_core: one byte in, one decode step per cycle unless the output stalls, results out
// a new byte is taken only in idle, once every result of the previous byte has reached the output register
// all results of every byte pass through the single shared decode step
// reset (rst_n, synchronous): clears the held byte count, the held result flag, the state machine and output valid
// held byte contents are not reset; they are written before they are ever read
module utf8_code_point_decoder_core import u8d_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  u8d_in_if.sink    in_chan,
  u8d_out_if.source out_chan
);

  u8d_cmd_t cmd;
  u8d_sts_t sts;

  u8d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8d_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte_value  (in_chan.byte_value),
    .in_text_last   (in_chan.text_last),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_code_point (out_chan.code_point),
    .out_run_last   (out_chan.run_last)
  );

endmodule

@@ tb/sv/utf8_code_point_decoder_core_tb.sv @@
`timescale 1ns / 100ps
// utf8_code_point_decoder_core_tb: drives utf-8 bytes into the core and checks its code points
// depends on u8d_pkg, u8d_in_if / u8d_out_if and utf8_code_point_decoder_core
module utf8_code_point_decoder_core_tb;
  import u8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            run_last;
  } cp_result_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            lst;
    logic            fixed;
    logic [CP_W-1:0] cp;
  } text_row_t;

  logic clk;
  logic rst_n;

  u8d_in_if  in_if();
  u8d_out_if out_if();

  utf8_code_point_decoder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [7:0]      held_bytes[$];
  logic [CP_W-1:0] step_cps[$];
  cp_result_t      cp_expect_q[$];
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     fail_cnt;

  // fixed rows carry a hand-typed result, the rest go through decode_byte
  text_row_t text_rows [0:22] = '{
    '{8'h41, 1'b0, 1'b1, 21'h000041},
    '{8'h00, 1'b0, 1'b1, 21'h000000},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F},
    '{8'h80, 1'b0, 1'b1, ERR_CP},
    '{8'hBF, 1'b0, 1'b1, ERR_CP},
    '{8'hF8, 1'b0, 1'b1, ERR_CP},
    '{8'hFF, 1'b0, 1'b1, ERR_CP},
    '{8'hC2, 1'b0, 1'b0, 21'h0},
    '{8'hA9, 1'b0, 1'b0, 21'h0},
    '{8'hE2, 1'b0, 1'b0, 21'h0},
    '{8'h82, 1'b0, 1'b0, 21'h0},
    '{8'hAC, 1'b1, 1'b0, 21'h0},
    '{8'hF7, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b1, 21'h1FFFFF},
    // broken four-byte window: lead rejected, then three plain bytes
    '{8'hF0, 1'b0, 1'b0, 21'h0},
    '{8'h41, 1'b0, 1'b0, 21'h0},
    '{8'h42, 1'b0, 1'b0, 21'h0},
    '{8'h43, 1'b0, 1'b0, 21'h0},
    // text ends inside a sequence
    '{8'hE2, 1'b0, 1'b0, 21'h0},
    '{8'h82, 1'b1, 1'b1, ERR_CP},
    '{8'hC2, 1'b1, 1'b1, ERR_CP}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned lead_len(input logic [7:0] c0);
    casez (c0)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // one byte into the held window; code points land in step_cps
  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    logic [7:0]      win[$];
    int unsigned     pos;
    int unsigned     need;
    logic [CP_W-1:0] cp;
    logic            broken;
    logic            stuck;
    win = held_bytes;
    win.insert(win.size(), b);
    step_cps.delete();
    pos = 0;
    stuck = 1'b0;
    while (pos < win.size() && !stuck) begin
      need = lead_len(win[pos]);
      if (need == 1) begin
        step_cps.insert(step_cps.size(), CP_W'(win[pos]));
        pos++;
      end else if (need == 0) begin
        step_cps.insert(step_cps.size(), ERR_CP);
        pos++;
      end else if (win.size() - pos < need) begin
        // short window: wait for more, or give up at end of text
        if (lst) begin
          step_cps.insert(step_cps.size(), ERR_CP);
          pos = win.size();
        end
        stuck = 1'b1;
      end else begin
        broken = 1'b0;
        case (need)
          2:       cp = CP_W'(win[pos][4:0]);
          3:       cp = CP_W'(win[pos][3:0]);
          default: cp = CP_W'(win[pos][2:0]);
        endcase
        for (int i = 1; i < need; i++) begin
          if (win[pos+i][7:6] != 2'b10) broken = 1'b1;
          cp = (cp << 6) | CP_W'(win[pos+i][5:0]);
        end
        if (broken) begin
          step_cps.insert(step_cps.size(), ERR_CP);
          pos++;
        end else begin
          step_cps.insert(step_cps.size(), cp);
          pos += need;
        end
      end
    end
    held_bytes.delete();
    for (int i = pos; i < win.size(); i++) held_bytes.insert(held_bytes.size(), win[i]);
  endfunction

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic fixed,
                           input logic [CP_W-1:0] fixed_cp);
    cp_result_t r;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_if.byte_value = b;
    in_if.text_last  = lst;
    in_if.valid      = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    decode_byte(b, lst);
    if (fixed) begin
      r.cp = fixed_cp;
      r.run_last = 1'b1;
      cp_expect_q.insert(cp_expect_q.size(), r);
    end else begin
      foreach (step_cps[i]) begin
        r.cp = step_cps[i];
        r.run_last = (i == step_cps.size() - 1);
        cp_expect_q.insert(cp_expect_q.size(), r);
      end
    end
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= stall_pct);
  end

  // result side: each transfer against the oldest expectation
  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (cp_expect_q.size() == 0) begin
        note_fail($sformatf("unexpected code point %h run_last %b",
                            out_if.code_point, out_if.run_last));
      end else begin
        want = cp_expect_q.pop_front();
        if (out_if.code_point !== want.cp || out_if.run_last !== want.run_last)
          note_fail($sformatf("code point exp %h got %h, run_last exp %b got %b",
                              want.cp, out_if.code_point, want.run_last, out_if.run_last));
      end
    end
  end

  initial begin
    logic [7:0]  chunk[$];
    logic [20:0] pay;
    int unsigned roll;
    int unsigned len;
    int unsigned sent;
    int unsigned drain;
    logic        text_end;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.byte_value = '0;
    in_if.text_last = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    fail_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (text_rows[i])
      send_byte(text_rows[i].b, text_rows[i].lst, text_rows[i].fixed, text_rows[i].cp);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < 64) begin
        roll = $urandom_range(99);
        len = $urandom_range(1, 4);
        pay = 21'($urandom());
        chunk.delete();
        case (len)
          1: chunk.insert(chunk.size(), {1'b0, pay[6:0]});
          2: begin
            chunk.insert(chunk.size(), {3'b110, pay[10:6]});
            chunk.insert(chunk.size(), {2'b10, pay[5:0]});
          end
          3: begin
            chunk.insert(chunk.size(), {4'b1110, pay[15:12]});
            chunk.insert(chunk.size(), {2'b10, pay[11:6]});
            chunk.insert(chunk.size(), {2'b10, pay[5:0]});
          end
          default: begin
            chunk.insert(chunk.size(), {5'b11110, pay[20:18]});
            chunk.insert(chunk.size(), {2'b10, pay[17:12]});
            chunk.insert(chunk.size(), {2'b10, pay[11:6]});
            chunk.insert(chunk.size(), {2'b10, pay[5:0]});
          end
        endcase
        text_end = ($urandom_range(7) == 0);
        if (roll < 12 && len > 1) begin
          chunk[$urandom_range(1, len - 1)] = 8'($urandom());
        end else if (roll < 20) begin
          // stray continuation or invalid byte ahead of the character
          if (roll < 16) chunk.push_front(8'($urandom_range(128, 191)));
          else chunk.push_front(8'($urandom_range(248, 255)));
        end else if (roll < 24) begin
          chunk.delete();
          chunk.insert(chunk.size(), 8'($urandom()));
        end else if (roll < 30 && len > 1) begin
          repeat ($urandom_range(1, len - 1)) chunk.delete(chunk.size() - 1);
          text_end = 1'b1;
        end
        foreach (chunk[i]) begin
          send_byte(chunk[i], text_end && (i == chunk.size() - 1), 1'b0, '0);
          sent++;
        end
      end
      // hold the sender until the decoder has drained
      while (cp_expect_q.size() != 0) @(negedge clk);
    end

    drain = 0;
    while (cp_expect_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    while (cp_expect_q.size() != 0) begin
      note_fail($sformatf("missing code point %h", cp_expect_q[0].cp));
      void'(cp_expect_q.pop_front());
    end
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
